@@ hdl/fers_pkg.sv @@
// Shared constants and codes for the filled ellipse row span generator.
`default_nettype none

package fers_pkg;

	// Default sizes handed to the top level.
	localparam int RADIUS_BITS_DEF = 11;
	localparam int ADDR_WIDTH_DEF  = 32;

	// Fixed field widths.
	localparam int COORD_BITS  = 12;
	localparam int COLOR_BITS  = 32;
	localparam int BASE_BITS   = 32;
	localparam int PITCH_BITS  = 16;
	localparam int PIX_BITS    = 3;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	// Pixel sizes in bytes.
	localparam logic [PIX_BITS-1:0] SINGLE_BYTE  = 3'd1;
	localparam logic [PIX_BITS-1:0] DOUBLE_BYTES = 3'd2;
	localparam logic [PIX_BITS-1:0] TRIPLE_BYTES = 3'd3;
	localparam logic [PIX_BITS-1:0] QUAD_BYTES   = 3'd4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_FRAME_BASE  = 2'd0,
		CFG_ROW_PITCH   = 2'd1,
		CFG_PIXEL_BYTES = 2'd2
	} cfg_index_t;

endpackage

`default_nettype wire

@@ hdl/fers_cfg_if.sv @@
// Configuration write channel of the row span generator.
`default_nettype none

interface fers_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [fers_pkg::CFG_IDX_BITS-1:0]   wr_index;
	logic [fers_pkg::CFG_DATA_BITS-1:0]  wr_data;

	modport source (output valid, output wr_index, output wr_data, input ready);
	modport sink   (input valid, input wr_index, input wr_data, output ready);
endinterface

`default_nettype wire

@@ hdl/fers_req_if.sv @@
// Row request channel: one ellipse row pair per transfer.
`default_nettype none

interface fers_req_if #(
	parameter int RADIUS_BITS = fers_pkg::RADIUS_BITS_DEF
);
	logic                              valid;
	logic                              ready;
	logic [fers_pkg::COORD_BITS-1:0]   center_x;
	logic [fers_pkg::COORD_BITS-1:0]   center_y;
	logic [RADIUS_BITS-1:0]            radius_x;
	logic [RADIUS_BITS-1:0]            radius_y;
	logic [RADIUS_BITS-1:0]            row_offset;
	logic [fers_pkg::COLOR_BITS-1:0]   fill_color;

	modport source (output valid, output center_x, output center_y, output radius_x,
		output radius_y, output row_offset, output fill_color, input ready);
	modport sink (input valid, input center_x, input center_y, input radius_x,
		input radius_y, input row_offset, input fill_color, output ready);
endinterface

`default_nettype wire

@@ hdl/fers_span_if.sv @@
// Span result channel: start addresses, length and color of a row pair.
`default_nettype none

interface fers_span_if #(
	parameter int RADIUS_BITS = fers_pkg::RADIUS_BITS_DEF,
	parameter int ADDR_WIDTH  = fers_pkg::ADDR_WIDTH_DEF
);
	logic                              valid;
	logic                              ready;
	logic [ADDR_WIDTH-1:0]             upper_address;
	logic [ADDR_WIDTH-1:0]             lower_address;
	logic [RADIUS_BITS:0]              span_pixels;
	logic [fers_pkg::COLOR_BITS-1:0]   span_color;
	logic                              single_row;
	logic                              beyond_edge;

	modport source (output valid, output upper_address, output lower_address,
		output span_pixels, output span_color, output single_row, output beyond_edge,
		input ready);
	modport sink (input valid, input upper_address, input lower_address,
		input span_pixels, input span_color, input single_row, input beyond_edge,
		output ready);
endinterface

`default_nettype wire

@@ hdl/filled_ellipse_row_span.sv @@
// Filled ellipse row span generator: one row pair request in, one span result out.
// Each request passes through stages 1 to 3, the root search, stage 5 and the output register.
// Throughput is one request per cycle unless the output stalls; the half width comes from a
// root search that resolves one bit per pipeline stage, RADIUS_BITS stages in all.
// Reset clears all valid bits and the configuration registers (pixel_bytes to 1).
`default_nettype none

module filled_ellipse_row_span #(
	parameter int RADIUS_BITS = fers_pkg::RADIUS_BITS_DEF,
	parameter int ADDR_WIDTH  = fers_pkg::ADDR_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	fers_cfg_if.sink   cfg,
	fers_req_if.sink   req,
	fers_span_if.source span
);

	localparam int RB  = RADIUS_BITS;
	localparam int AW  = ADDR_WIDTH;
	localparam int RB2 = 2 * RB;
	localparam int RB3 = 3 * RB;
	localparam int RB4 = 4 * RB;
	// The trial subtraction needs room for a delta of up to 4*RB+1 bits plus a sign.
	localparam int DW  = RB4 + 2;
	localparam int CMW = fers_pkg::COORD_BITS + fers_pkg::PITCH_BITS;
	localparam int ESW = RB + fers_pkg::PITCH_BITS;

	// Stage positions in the valid chain. The search occupies RB consecutive stages.
	localparam int ST_S1   = 0;
	localparam int ST_S2   = 1;
	localparam int ST_S3   = 2;
	localparam int ST_SRCH = 3;
	localparam int ST_S5   = RB + 3;
	localparam int ST_S6   = RB + 4;
	localparam int NST     = RB + 5;

	// Per-item data that rides along the root search untouched.
	typedef struct packed {
		logic [fers_pkg::COORD_BITS-1:0] cx;
		logic [RB-1:0]                   rx;
		logic                            ey_zero;
		logic                            beyond;
		logic [fers_pkg::COLOR_BITS-1:0] color;
		logic [AW-1:0]                   upb;
		logic [AW-1:0]                   dnb;
		logic [RB2-1:0]                  d;
	} side_t;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken at once.
	// ------------------------------------------------------------------
	logic [fers_pkg::BASE_BITS-1:0]  frame_base_q;
	logic [fers_pkg::PITCH_BITS-1:0] row_pitch_q;
	logic [fers_pkg::PIX_BITS-1:0]   pixel_bytes_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= '0;
			row_pitch_q   <= '0;
			pixel_bytes_q <= fers_pkg::SINGLE_BYTE;
		end else if (cfg.valid) begin
			unique case (cfg.wr_index)
				fers_pkg::CFG_FRAME_BASE: begin
					frame_base_q <= cfg.wr_data[fers_pkg::BASE_BITS-1:0];
				end
				fers_pkg::CFG_ROW_PITCH: begin
					row_pitch_q <= cfg.wr_data[fers_pkg::PITCH_BITS-1:0];
				end
				fers_pkg::CFG_PIXEL_BYTES: begin
					pixel_bytes_q <= cfg.wr_data[fers_pkg::PIX_BITS-1:0];
				end
				default: begin
					// Writes to unused indexes are dropped.
				end
			endcase
		end
	end

	// A pixel size of zero behaves as one byte, anything above four as four.
	// The row step is the pitch rounded down to whole pixels for the 2 and
	// 4 byte sizes; 1 and 3 byte pixels step by the pitch itself.
	logic [fers_pkg::PIX_BITS-1:0]   pix_bytes;
	logic [fers_pkg::PITCH_BITS-1:0] row_step;

	always_comb begin
		if (pixel_bytes_q == '0) begin
			pix_bytes = fers_pkg::SINGLE_BYTE;
		end else if (pixel_bytes_q > fers_pkg::QUAD_BYTES) begin
			pix_bytes = fers_pkg::QUAD_BYTES;
		end else begin
			pix_bytes = pixel_bytes_q;
		end
		case (pix_bytes)
			fers_pkg::DOUBLE_BYTES: row_step = row_pitch_q & ~16'h0001;
			fers_pkg::QUAD_BYTES:   row_step = row_pitch_q & ~16'h0003;
			default:                row_step = row_pitch_q;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control. Each stage moves when it is empty or its successor
	// moves, so bubbles collapse and a stalled output only holds back the
	// stages that are actually full.
	// ------------------------------------------------------------------
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	assign en[NST-1] = !vld_q[NST-1] || span.ready;
	for (genvar i = 0; i < NST - 1; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end

	assign req.ready = en[ST_S1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[ST_S1]) begin
				vld_q[ST_S1] <= req.valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: squares of the radii and the offset, and the two address
	// products (center row times pitch, offset times row step).
	// ------------------------------------------------------------------
	logic [RB2-1:0]                  rx2_s1;
	logic [RB2-1:0]                  ry2_s1;
	logic [RB2-1:0]                  ey2_s1;
	logic [CMW-1:0]                  cmul_s1;
	logic [ESW-1:0]                  eystep_s1;
	logic [fers_pkg::COORD_BITS-1:0] cx_s1;
	logic [RB-1:0]                   rx_s1;
	logic                            ey_zero_s1;
	logic                            beyond_s1;
	logic [fers_pkg::COLOR_BITS-1:0] color_s1;

	always_ff @(posedge clk) begin
		if (en[ST_S1]) begin
			rx2_s1     <= RB2'(req.radius_x) * RB2'(req.radius_x);
			ry2_s1     <= RB2'(req.radius_y) * RB2'(req.radius_y);
			ey2_s1     <= RB2'(req.row_offset) * RB2'(req.row_offset);
			cmul_s1    <= CMW'(req.center_y) * CMW'(row_pitch_q);
			eystep_s1  <= ESW'(req.row_offset) * ESW'(row_step);
			cx_s1      <= req.center_x;
			rx_s1      <= req.radius_x;
			ey_zero_s1 <= (req.row_offset == '0);
			beyond_s1  <= (req.row_offset > req.radius_y);
			color_s1   <= req.fill_color;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: ry^2 - ey^2 and the center row address. The difference is
	// meaningless for an offset beyond the edge, which is masked at the end.
	// ------------------------------------------------------------------
	logic [RB2-1:0]                  diff_s2;
	logic [RB2-1:0]                  rx2_s2;
	logic [RB2-1:0]                  ry2_s2;
	logic [AW-1:0]                   center_s2;
	logic [AW-1:0]                   eystep_s2;
	logic [fers_pkg::COORD_BITS-1:0] cx_s2;
	logic [RB-1:0]                   rx_s2;
	logic                            ey_zero_s2;
	logic                            beyond_s2;
	logic [fers_pkg::COLOR_BITS-1:0] color_s2;

	always_ff @(posedge clk) begin
		if (en[ST_S2]) begin
			diff_s2    <= ry2_s1 - ey2_s1;
			rx2_s2     <= rx2_s1;
			ry2_s2     <= ry2_s1;
			center_s2  <= AW'(frame_base_q) + AW'(cmul_s1);
			eystep_s2  <= AW'(eystep_s1);
			cx_s2      <= cx_s1;
			rx_s2      <= rx_s1;
			ey_zero_s2 <= ey_zero_s1;
			beyond_s2  <= beyond_s1;
			color_s2   <= color_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: the search target N = rx^2 * (ry^2 - ey^2), and the row
	// bases above and below the center.
	// ------------------------------------------------------------------
	logic [RB4-1:0] num_s3;
	side_t          side_s3;

	always_ff @(posedge clk) begin
		if (en[ST_S3]) begin
			num_s3          <= RB4'(rx2_s2) * RB4'(diff_s2);
			side_s3.cx      <= cx_s2;
			side_s3.rx      <= rx_s2;
			side_s3.ey_zero <= ey_zero_s2;
			side_s3.beyond  <= beyond_s2;
			side_s3.color   <= color_s2;
			side_s3.upb     <= center_s2 - eystep_s2;
			side_s3.dnb     <= center_s2 + eystep_s2;
			side_s3.d       <= ry2_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 (RB register stages): the half width h is the largest value
	// with h^2 * D <= N, where D = ry^2. Each stage tries one bit of h,
	// from the top. The remainder R = N - h^2*D and the product h*D are
	// carried along, so setting bit k costs D*(2h + 2^k)*2^k, which is
	// (h*D) << (k+1) plus D << 2k: one wide subtract decides the bit.
	// ------------------------------------------------------------------
	logic [RB4-1:0] rem_s4  [RB];
	logic [RB3-1:0] hd_s4   [RB];
	logic [RB-1:0]  h_s4    [RB];
	side_t          side_s4 [RB];

	for (genvar j = 0; j < RB; j++) begin : g_srch
		localparam int K = RB - 1 - j;

		logic [RB4-1:0] rem_in;
		logic [RB3-1:0] hd_in;
		logic [RB-1:0]  h_in;
		side_t          sd_in;
		logic [DW-1:0]  delta;
		logic [DW-1:0]  trial;
		logic           fits;

		if (j == 0) begin : g_first
			assign rem_in = num_s3;
			assign hd_in  = '0;
			assign h_in   = '0;
			assign sd_in  = side_s3;
		end else begin : g_next
			assign rem_in = rem_s4[j-1];
			assign hd_in  = hd_s4[j-1];
			assign h_in   = h_s4[j-1];
			assign sd_in  = side_s4[j-1];
		end

		assign delta = (DW'(hd_in) << (K + 1)) + (DW'(sd_in.d) << (2 * K));
		assign trial = DW'(rem_in) - delta;
		assign fits  = !trial[DW-1];

		always_ff @(posedge clk) begin
			if (en[ST_SRCH + j]) begin
				rem_s4[j]  <= fits ? trial[RB4-1:0] : rem_in;
				hd_s4[j]   <= fits ? hd_in + (RB3'(sd_in.d) << K) : hd_in;
				h_s4[j]    <= h_in | (RB'(fits) << K);
				side_s4[j] <= sd_in;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: choose the half width (offset zero always spans the full
	// horizontal radius, also for a flat ellipse) and scale the span's left
	// column by the pixel size. Multiplying by 1 to 4 is a shift and add.
	// ------------------------------------------------------------------
	side_t          last_side;
	logic [RB-1:0]  half;
	logic [AW-1:0]  left_col;
	logic [AW-1:0]  left_byte;

	assign last_side = side_s4[RB-1];
	assign half      = last_side.ey_zero ? last_side.rx : h_s4[RB-1];
	assign left_col  = AW'(last_side.cx) - AW'(half);

	always_comb begin
		case (pix_bytes)
			fers_pkg::DOUBLE_BYTES: left_byte = left_col << 1;
			fers_pkg::TRIPLE_BYTES: left_byte = (left_col << 1) + left_col;
			fers_pkg::QUAD_BYTES:   left_byte = left_col << 2;
			default:                left_byte = left_col;
		endcase
	end

	logic [RB-1:0]  half_s5;
	logic [AW-1:0]  left_s5;
	side_t          side_s5;

	always_ff @(posedge clk) begin
		if (en[ST_S5]) begin
			half_s5 <= half;
			left_s5 <= left_byte;
			side_s5 <= last_side;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: output register. An offset beyond the vertical radius gives
	// an empty span at address zero; the color still passes through.
	// ------------------------------------------------------------------
	logic [AW-1:0]                   upper_s6;
	logic [AW-1:0]                   lower_s6;
	logic [RB:0]                     pixels_s6;
	logic [fers_pkg::COLOR_BITS-1:0] color_s6;
	logic                            single_s6;
	logic                            beyond_s6;

	always_ff @(posedge clk) begin
		if (en[ST_S6]) begin
			upper_s6  <= side_s5.beyond ? '0 : side_s5.upb + left_s5;
			lower_s6  <= side_s5.beyond ? '0 : side_s5.dnb + left_s5;
			pixels_s6 <= side_s5.beyond ? '0 : {half_s5, 1'b1};
			color_s6  <= side_s5.color;
			single_s6 <= side_s5.ey_zero;
			beyond_s6 <= side_s5.beyond;
		end
	end

	assign span.valid         = vld_q[ST_S6];
	assign span.upper_address = upper_s6;
	assign span.lower_address = lower_s6;
	assign span.span_pixels   = pixels_s6;
	assign span.span_color    = color_s6;
	assign span.single_row    = single_s6;
	assign span.beyond_edge   = beyond_s6;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------

	// The root search never overshoots the horizontal radius.
	a_half_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_S5] && !side_s5.beyond |-> half_s5 <= side_s5.rx)
		else $error("half width exceeds horizontal radius");

	// On the center row both spans start at the same byte.
	a_single_row_same: assert property (@(posedge clk) disable iff (!arst_n)
		span.valid && span.single_row && !span.beyond_edge
		|-> span.upper_address == span.lower_address)
		else $error("center row spans start at different addresses");

	// A span inside the ellipse always has an odd pixel count.
	a_span_odd: assert property (@(posedge clk) disable iff (!arst_n)
		span.valid && !span.beyond_edge |-> span.span_pixels[0])
		else $error("span pixel count is even");

	// A full stage 5 that cannot advance keeps its item.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_S5] && !en[ST_S5] |=> vld_q[ST_S5])
		else $error("stalled item lost");

endmodule

`default_nettype wire

@@ test/tb_filled_ellipse_row_span.sv @@
// Self-checking testbench for the filled ellipse row span generator.
`timescale 1ns / 100ps

module tb_filled_ellipse_row_span;

	localparam int RB = fers_pkg::RADIUS_BITS_DEF;
	localparam int AW = fers_pkg::ADDR_WIDTH_DEF;

	// Request to result latency of the block.
	localparam int LATENCY = RB + 5;

	// The longest correct stretch without any transfer is one pipeline
	// latency plus a sender gap and a receiver stall. The pause between
	// phases is about the same. The limit below is many times that.
	localparam int WATCHDOG_LIMIT = 2000;

	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int MAX_REPORTS     = 200;

	// Register index with no register behind it. Writes to it must be dropped.
	localparam logic [fers_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

	// Pixel size codes outside 1 to 4. Zero acts as one byte, 5 to 7 as four.
	localparam logic [fers_pkg::PIX_BITS-1:0] PIX_BELOW_RANGE = 3'd0;
	localparam logic [fers_pkg::PIX_BITS-1:0] PIX_ABOVE_LOW   = 3'd5;
	localparam logic [fers_pkg::PIX_BITS-1:0] PIX_ABOVE_HIGH  = 3'd7;

	typedef struct {
		logic [fers_pkg::COORD_BITS-1:0] cx;
		logic [fers_pkg::COORD_BITS-1:0] cy;
		logic [RB-1:0]                   rx;
		logic [RB-1:0]                   ry;
		logic [RB-1:0]                   ey;
		logic [fers_pkg::COLOR_BITS-1:0] color;
	} row_req_t;

	typedef struct {
		logic [AW-1:0]                   upper;
		logic [AW-1:0]                   lower;
		logic [RB:0]                     pixels;
		logic [fers_pkg::COLOR_BITS-1:0] color;
		logic                            single;
		logic                            beyond;
	} span_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	fers_cfg_if                            cfg_bus ();
	fers_req_if  #(.RADIUS_BITS(RB))                  req_bus ();
	fers_span_if #(.RADIUS_BITS(RB), .ADDR_WIDTH(AW)) span_bus ();

	filled_ellipse_row_span #(
		.RADIUS_BITS(RB),
		.ADDR_WIDTH (AW)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.req   (req_bus),
		.span  (span_bus)
	);

	// Rows waiting to be offered, and spans predicted for accepted rows, oldest first.
	row_req_t row_requests[$];
	span_t    spans_due[$];

	// Our own copy of the configuration registers, updated on each config transfer.
	logic [fers_pkg::BASE_BITS-1:0]  base_reg;
	logic [fers_pkg::PITCH_BITS-1:0] pitch_reg;
	logic [fers_pkg::PIX_BITS-1:0]   pix_reg;

	bit idle_enable;
	int gap_left;
	int stall_left;
	int quiet_cycles;
	int errors = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected span for one row pair under the current register settings.
	// The half width is the largest h with h^2 * ry^2 <= rx^2 * (ry^2 - ey^2),
	// found bit by bit from the top, which is the exact integer square root.
	function automatic span_t span_of_row(row_req_t r);
		span_t                           s;
		logic [fers_pkg::PIX_BITS-1:0]   pb;
		logic [fers_pkg::PITCH_BITS-1:0] step;
		logic [RB-1:0]                   half;
		logic [RB-1:0]                   trial;
		logic [63:0]                     ry2;
		logic [63:0]                     limit;
		logic [AW-1:0]                   center;
		logic [AW-1:0]                   left;
		logic [AW-1:0]                   rows;
		s.color  = r.color;
		s.single = (r.ey == '0);
		s.beyond = (r.ey > r.ry);
		s.upper  = '0;
		s.lower  = '0;
		s.pixels = '0;
		if (!s.beyond) begin
			if (r.ey == '0) begin
				// The center row always spans the full width, even with no vertical radius.
				half = r.rx;
			end else begin
				ry2   = 64'(r.ry) * 64'(r.ry);
				limit = 64'(r.rx) * 64'(r.rx) * (ry2 - 64'(r.ey) * 64'(r.ey));
				half  = '0;
				for (int b = RB - 1; b >= 0; b--) begin
					trial = half | (RB'(1) << b);
					if (64'(trial) * 64'(trial) * ry2 <= limit)
						half = trial;
				end
			end
			pb = pix_reg;
			if (pb == PIX_BELOW_RANGE)
				pb = fers_pkg::SINGLE_BYTE;
			else if (pb > fers_pkg::QUAD_BYTES)
				pb = fers_pkg::QUAD_BYTES;
			// The row step is the pitch rounded down to whole pixels; at three
			// bytes per pixel it is left as it is.
			step = pitch_reg;
			if (pb == fers_pkg::DOUBLE_BYTES)
				step[0] = 1'b0;
			else if (pb == fers_pkg::QUAD_BYTES)
				step[1:0] = 2'b00;
			// Everything wraps modulo the address width, so a span left of column 0
			// or a row above row 0 just wraps around.
			center  = AW'(base_reg) + AW'(r.cy) * AW'(pitch_reg);
			left    = (AW'(r.cx) - AW'(half)) * AW'(pb);
			rows    = AW'(r.ey) * AW'(step);
			s.upper = center - rows + left;
			s.lower = center + rows + left;
			s.pixels = {half, 1'b1};
		end
		return s;
	endfunction

	function automatic row_req_t mk_row(int cx, int cy, int rx, int ry, int ey,
		logic [fers_pkg::COLOR_BITS-1:0] color);
		row_req_t r;
		r.cx    = fers_pkg::COORD_BITS'(cx);
		r.cy    = fers_pkg::COORD_BITS'(cy);
		r.rx    = RB'(rx);
		r.ry    = RB'(ry);
		r.ey    = RB'(ey);
		r.color = color;
		return r;
	endfunction

	// Random row pair. Most requests are well formed, with the offset inside
	// the vertical radius, and most radii are small so that the edge rows and
	// rounding of small ellipses are hit often. The rest spread over the full
	// field ranges, with some offsets past the edge.
	function automatic row_req_t random_row();
		row_req_t r;
		int       pick;
		r.cx    = fers_pkg::COORD_BITS'($urandom_range(0, (1 << fers_pkg::COORD_BITS) - 1));
		r.cy    = fers_pkg::COORD_BITS'($urandom_range(0, (1 << fers_pkg::COORD_BITS) - 1));
		r.color = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			r.rx = RB'($urandom_range(0, 31));
			r.ry = RB'($urandom_range(0, 31));
		end else if (pick < 9) begin
			r.rx = RB'($urandom_range(0, (1 << RB) - 1));
			r.ry = RB'($urandom_range(0, (1 << RB) - 1));
		end else begin
			r.rx = $urandom_range(0, 1) ? '1 : RB'($urandom_range(0, 3));
			r.ry = $urandom_range(0, 1) ? '1 : RB'($urandom_range(0, 3));
		end
		pick = $urandom_range(0, 19);
		if (pick < 17)
			r.ey = RB'($urandom_range(0, int'(r.ry)));
		else if (pick < 18)
			r.ey = '0;
		else
			r.ey = RB'($urandom_range(0, (1 << RB) - 1));
		return r;
	endfunction

	// Corner cases of the fields: full width rows, zero and maximum radii,
	// offsets on and just past the edge, spans that start left of column 0
	// and rows above row 0.
	task automatic queue_corner_rows();
		row_requests.push_back(mk_row(0, 0, 2047, 0, 0, 32'hFFFF_FFFF));
		row_requests.push_back(mk_row(100, 100, 50, 0, 1, 32'h1234_5678));
		row_requests.push_back(mk_row(0, 0, 0, 0, 0, 32'h0000_0000));
		row_requests.push_back(mk_row(4095, 4095, 2047, 2047, 2047, 32'hFFFF_FFFF));
		row_requests.push_back(mk_row(2048, 2048, 2047, 2046, 2047, 32'hA5A5_A5A5));
		row_requests.push_back(mk_row(4095, 4095, 2047, 2047, 1, 32'h5A5A_5A5A));
		row_requests.push_back(mk_row(10, 10, 0, 5, 3, 32'h0F0F_0F0F));
		row_requests.push_back(mk_row(7, 3, 9, 1, 1, 32'hF0F0_F0F0));
		row_requests.push_back(mk_row(3, 500, 40, 40, 10, 32'h8000_0001));
		row_requests.push_back(mk_row(600, 2, 30, 60, 20, 32'h7FFF_FFFE));
		row_requests.push_back(mk_row(1000, 800, 100, 50, 30, 32'hDEAD_BEEF));
		row_requests.push_back(mk_row(320, 240, 200, 120, 60, 32'h0012_3456));
		row_requests.push_back(mk_row(2047, 2047, 1023, 511, 0, 32'hCAFE_F00D));
	endtask

	// One register write. The channel valid stays high across back to back
	// writes and is lowered once by the caller after the last of them.
	task automatic write_reg(logic [fers_pkg::CFG_IDX_BITS-1:0] idx,
		logic [fers_pkg::CFG_DATA_BITS-1:0] data);
		cfg_bus.valid    <= 1'b1;
		cfg_bus.wr_index <= idx;
		cfg_bus.wr_data  <= data;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
	endtask

	// Writes all three registers. Upper data bits beyond each register's width
	// are random so that the register must drop them. Optionally a write to
	// the unused index goes in between, which must change nothing.
	task automatic program_regs(logic [fers_pkg::BASE_BITS-1:0] base,
		logic [fers_pkg::PITCH_BITS-1:0] pitch, logic [fers_pkg::PIX_BITS-1:0] pix,
		bit poke_unused);
		write_reg(fers_pkg::CFG_FRAME_BASE, base);
		if (poke_unused)
			write_reg(CFG_UNUSED, $urandom);
		write_reg(fers_pkg::CFG_ROW_PITCH, {16'($urandom), pitch});
		write_reg(fers_pkg::CFG_PIXEL_BYTES, {29'($urandom), pix});
		cfg_bus.valid <= 1'b0;
	endtask

	// Waits until every queued row has been taken and every span has come
	// back, then lets the pipeline run empty before registers may change.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (row_requests.size() != 0 || req_bus.valid || spans_due.size() != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			if (errors < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Our register copy follows every config transfer the block accepts. The
	// writes land only while no request is in flight, so the predictor always
	// sees the settings the block used.
	always @(posedge clk) begin
		if (!arst_n) begin
			base_reg  = '0;
			pitch_reg = '0;
			pix_reg   = fers_pkg::SINGLE_BYTE;
		end else if (cfg_bus.valid && cfg_bus.ready) begin
			case (cfg_bus.wr_index)
				fers_pkg::CFG_FRAME_BASE:  base_reg  = cfg_bus.wr_data[fers_pkg::BASE_BITS-1:0];
				fers_pkg::CFG_ROW_PITCH:   pitch_reg = cfg_bus.wr_data[fers_pkg::PITCH_BITS-1:0];
				fers_pkg::CFG_PIXEL_BYTES: pix_reg   = cfg_bus.wr_data[fers_pkg::PIX_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Request driver. On each transfer the accepted row is predicted and
	// retired from the queue. A row that was offered but not yet taken stays
	// on the bus unchanged. Otherwise the next row is offered, unless an idle
	// burst is running or starts now.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_bus.valid && req_bus.ready)
				spans_due.push_back(span_of_row(row_requests.pop_front()));
			if (req_bus.valid && !req_bus.ready) begin
				// Hold the offered row until the block takes it.
			end else if (gap_left > 0) begin
				gap_left--;
				req_bus.valid <= 1'b0;
			end else if (idle_enable && row_requests.size() != 0
				&& $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(1, 6) - 1;
				req_bus.valid <= 1'b0;
			end else if (row_requests.size() != 0) begin
				req_bus.valid      <= 1'b1;
				req_bus.center_x   <= row_requests[0].cx;
				req_bus.center_y   <= row_requests[0].cy;
				req_bus.radius_x   <= row_requests[0].rx;
				req_bus.radius_y   <= row_requests[0].ry;
				req_bus.row_offset <= row_requests[0].ey;
				req_bus.fill_color <= row_requests[0].color;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// Span monitor. Each span transfer is checked field by field against the
	// oldest prediction. Ready drops in random stall bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			span_bus.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (span_bus.valid && span_bus.ready) begin
				if (spans_due.size() == 0) begin
					if (errors < MAX_REPORTS)
						$display("%0t: unexpected span, expected none, actual %0h %0h %0h %0h %b %b",
							$time, span_bus.upper_address, span_bus.lower_address,
							span_bus.span_pixels, span_bus.span_color, span_bus.single_row,
							span_bus.beyond_edge);
					errors++;
				end else begin
					span_t want;
					want = spans_due.pop_front();
					check_field("upper_address", want.upper, span_bus.upper_address);
					check_field("lower_address", want.lower, span_bus.lower_address);
					check_field("span_pixels", want.pixels, span_bus.span_pixels);
					check_field("span_color", want.color, span_bus.span_color);
					check_field("single_row", want.single, span_bus.single_row);
					check_field("beyond_edge", want.beyond, span_bus.beyond_edge);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				span_bus.ready <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				span_bus.ready <= 1'b0;
			end else begin
				span_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (span_bus.valid && span_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("tb_filled_ellipse_row_span: done, errors");
				$finish;
			end
		end
	end

	// Run sequence: corner rows under the reset settings, the same rows under
	// the extreme settings, then phases of random rows, each phase under its
	// own register settings. The out of range pixel sizes 0, 5 and 7 each get a phase.
	// The last phase runs without idling on either side.
	initial begin
		logic [fers_pkg::PIX_BITS-1:0] pix;
		cfg_bus.valid       = 1'b0;
		cfg_bus.wr_index    = '0;
		cfg_bus.wr_data     = '0;
		idle_enable         = 1'b1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: no base, no pitch, one byte per pixel.
		queue_corner_rows();
		wait_drained();

		program_regs('1, '1, fers_pkg::QUAD_BYTES, 1'b1);
		queue_corner_rows();
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: program_regs('0, 16'd1, fers_pkg::TRIPLE_BYTES, 1'b0);
				1: program_regs($urandom, 16'($urandom) | 16'd1, PIX_BELOW_RANGE, 1'b1);
				2: program_regs($urandom, 16'($urandom), PIX_ABOVE_HIGH, 1'b0);
				3: program_regs($urandom, 16'($urandom), PIX_ABOVE_LOW, 1'b0);
				4: program_regs($urandom, 16'($urandom) | 16'd1, fers_pkg::DOUBLE_BYTES, 1'b1);
				5: program_regs('1, 16'd0, fers_pkg::SINGLE_BYTE, 1'b0);
				default: begin
					if ($urandom_range(0, 7) == 0)
						pix = fers_pkg::PIX_BITS'($urandom_range(0, 7));
					else
						pix = fers_pkg::PIX_BITS'($urandom_range(1, 4));
					program_regs($urandom, 16'($urandom), pix, $urandom_range(0, 1));
				end
			endcase
			// Phase 2, every fourth phase after it and the last phase run flat out with no idling.
			idle_enable = (phase != RANDOM_PHASES - 1) && (phase % 4 != 2);
			repeat (ITEMS_PER_PHASE) row_requests.push_back(random_row());
			wait_drained();
		end

		// Any late or extra span would show up in this window.
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0)
			$display("tb_filled_ellipse_row_span: done, clean");
		else
			$display("tb_filled_ellipse_row_span: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/fers_pkg.sv
hdl/fers_cfg_if.sv
hdl/fers_req_if.sv
hdl/fers_span_if.sv
hdl/filled_ellipse_row_span.sv
test/tb_filled_ellipse_row_span.sv
